// ===== rtl/pfcb_pkg.sv =====
// Shared types, constants and helper functions for the pixel format converter.
package pfcb_pkg;

  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NCH        = 3;
  localparam int NFIELD     = 4;
  localparam int OFF_W      = 5;
  localparam int WID_W      = 6;
  localparam int LAY_STRIDE = 11;
  localparam int SRC_LAY_W  = 44;
  localparam int DST_LAY_W  = 33;
  localparam int BG_W       = 24;
  localparam int PROD_W     = 2 * CH_W;
  localparam int SUM_W      = 10;
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;
  localparam int ALPHA_IDX  = 3;

  localparam logic [CH_W-1:0]  FULL_SCALE = 8'd255;
  localparam logic [CH_W-1:0]  DEFAULT_BG = 8'd180;
  localparam logic [WID_W-1:0] CHAN_BITS  = 6'd8;
  localparam logic [WID_W-1:0] WIDE_FIELD = 6'd6;
  localparam logic [WID_W-1:0] FULL_WORD  = 6'd32;

  // floor(x/3) == (x*683) >> 11 for every channel sum up to 765
  localparam logic [SUM_W-1:0] DIV3_RECIP = 10'd683;
  localparam int               DIV3_SHIFT = 11;

  // source modes
  localparam logic [2:0] SRC_GRAY8        = 3'd0;
  localparam logic [2:0] SRC_RGB16        = 3'd1;
  localparam logic [2:0] SRC_GRAY_ALPHA16 = 3'd2;
  localparam logic [2:0] SRC_RGB24        = 3'd3;
  localparam logic [2:0] SRC_RGBA32       = 3'd4;

  // destination modes
  localparam logic [1:0] DST_GRAY8  = 2'd0;
  localparam logic [1:0] DST_RGB16  = 2'd1;
  localparam logic [1:0] DST_PACKED = 2'd2;
  localparam logic [1:0] DST_WIDE   = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_SRC_MODE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_LAYOUT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DST_MODE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DST_LAYOUT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CUSTOM_BG  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PREMULT    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BG_RGB     = 3'd6;

  typedef struct packed {
    logic [PIX_W-1:0] src_pixel;
    logic             last_pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] dst_pixel;
    logic             last_out;
  } out_t;

  typedef struct packed {
    logic [2:0]           src_mode;
    logic [SRC_LAY_W-1:0] src_layout;
    logic [1:0]           dst_mode;
    logic [DST_LAY_W-1:0] dst_layout;
    logic                 custom_bg;
    logic                 premult;
    logic [BG_W-1:0]      bg_rgb;
  } cfg_t;

  // decoded pixel, decode -> blend
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic                      blend;
    logic [CH_W-1:0]           alpha;
    logic [NCH-1:0][CH_W-1:0]  ch;
  } dec_t;

  // blended pixel, blend -> pack
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic [NCH-1:0][CH_W-1:0]  ch;
    logic [SUM_W-1:0]          sum;
  } mix_t;

  function automatic logic [OFF_W-1:0] lay_off(input logic [SRC_LAY_W-1:0] lay,
                                               input int unsigned c);
    return lay[LAY_STRIDE*c +: OFF_W];
  endfunction

  function automatic logic [WID_W-1:0] lay_wid(input logic [SRC_LAY_W-1:0] lay,
                                               input int unsigned c);
    return lay[LAY_STRIDE*c + OFF_W +: WID_W];
  endfunction

  function automatic logic [PIX_W-1:0] field_mask(input logic [WID_W-1:0] w);
    logic [PIX_W:0] m;
    m = ({{PIX_W{1'b0}}, 1'b1} << w) - {{PIX_W{1'b0}}, 1'b1};
    if (w >= FULL_WORD) begin
      return {PIX_W{1'b1}};
    end
    return m[PIX_W-1:0];
  endfunction

endpackage

// ===== rtl/pfcb_cfg.sv =====
// APB-style configuration register file for the pixel format converter.
module pfcb_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pfcb_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [pfcb_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [pfcb_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  output pfcb_pkg::cfg_t                     cfg_o
);

  pfcb_pkg::cfg_t                    cfg_r;
  logic                              wr_en;
  logic [pfcb_pkg::REG_IDX_W-1:0]    idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[pfcb_pkg::APB_ADDR_W-1 -: pfcb_pkg::REG_IDX_W];
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_mode   <= pfcb_pkg::SRC_RGB24;
      cfg_r.src_layout <= '0;
      cfg_r.dst_mode   <= pfcb_pkg::DST_PACKED;
      cfg_r.dst_layout <= '0;
      cfg_r.custom_bg  <= 1'b0;
      cfg_r.premult    <= 1'b0;
      cfg_r.bg_rgb     <= {pfcb_pkg::DEFAULT_BG, pfcb_pkg::DEFAULT_BG,
                           pfcb_pkg::DEFAULT_BG};
    end else if (wr_en) begin
      unique case (idx)
        pfcb_pkg::REG_SRC_MODE:   cfg_r.src_mode   <= cfg_pwdata[2:0];
        pfcb_pkg::REG_SRC_LAYOUT: cfg_r.src_layout <= cfg_pwdata[pfcb_pkg::SRC_LAY_W-1:0];
        pfcb_pkg::REG_DST_MODE:   cfg_r.dst_mode   <= cfg_pwdata[1:0];
        pfcb_pkg::REG_DST_LAYOUT: cfg_r.dst_layout <= cfg_pwdata[pfcb_pkg::DST_LAY_W-1:0];
        pfcb_pkg::REG_CUSTOM_BG:  cfg_r.custom_bg  <= cfg_pwdata[0];
        pfcb_pkg::REG_PREMULT:    cfg_r.premult    <= cfg_pwdata[0];
        pfcb_pkg::REG_BG_RGB:     cfg_r.bg_rgb     <= cfg_pwdata[pfcb_pkg::BG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      pfcb_pkg::REG_SRC_MODE:   cfg_prdata[2:0] = cfg_r.src_mode;
      pfcb_pkg::REG_SRC_LAYOUT: cfg_prdata[pfcb_pkg::SRC_LAY_W-1:0] = cfg_r.src_layout;
      pfcb_pkg::REG_DST_MODE:   cfg_prdata[1:0] = cfg_r.dst_mode;
      pfcb_pkg::REG_DST_LAYOUT: cfg_prdata[pfcb_pkg::DST_LAY_W-1:0] = cfg_r.dst_layout;
      pfcb_pkg::REG_CUSTOM_BG:  cfg_prdata[0] = cfg_r.custom_bg;
      pfcb_pkg::REG_PREMULT:    cfg_prdata[0] = cfg_r.premult;
      pfcb_pkg::REG_BG_RGB:     cfg_prdata[pfcb_pkg::BG_W-1:0] = cfg_r.bg_rgb;
      default: ;
    endcase
  end

endmodule

// ===== rtl/pfcb_decode.sv =====
// Two-stage source decode: field extraction, then scaling to 8-bit channels.
module pfcb_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  pfcb_pkg::in_t   in_data,
  input  pfcb_pkg::cfg_t  cfg,
  output pfcb_pkg::dec_t  dec_o
);

  logic                                                  s1_valid_r;
  logic                                                  s1_last_r;
  logic [pfcb_pkg::CH_W-1:0]                             s1_gray_r;
  logic [pfcb_pkg::NFIELD-1:0][pfcb_pkg::PIX_W-1:0]      s1_field_r;
  logic [pfcb_pkg::NFIELD-1:0][pfcb_pkg::PIX_W-1:0]      field_nxt;
  logic [pfcb_pkg::PIX_W-1:0]                            word;
  pfcb_pkg::dec_t                                        dec_r;
  pfcb_pkg::dec_t                                        dec_nxt;
  logic [pfcb_pkg::WID_W-1:0]                            w;

  function automatic logic [pfcb_pkg::CH_W-1:0] wide_down(
    input logic [pfcb_pkg::PIX_W-1:0] f,
    input logic [pfcb_pkg::WID_W-1:0] fw
  );
    logic [pfcb_pkg::WID_W-1:0] sh;
    logic [pfcb_pkg::PIX_W-1:0] v;
    sh = fw - pfcb_pkg::CHAN_BITS;
    v  = f;
    if (fw > pfcb_pkg::CHAN_BITS) begin
      v = (sh >= pfcb_pkg::FULL_WORD) ? '0 : (f >> sh[pfcb_pkg::OFF_W-1:0]);
    end
    return v[pfcb_pkg::CH_W-1:0];
  endfunction

  // trim the word to the source format's size, then pull out all four fields
  always_comb begin
    word = in_data.src_pixel;
    priority if (cfg.src_mode == pfcb_pkg::SRC_RGB16 ||
                 cfg.src_mode == pfcb_pkg::SRC_GRAY_ALPHA16) begin
      word = {16'b0, in_data.src_pixel[15:0]};
    end else if (cfg.src_mode == pfcb_pkg::SRC_RGB24) begin
      word = {8'b0, in_data.src_pixel[23:0]};
    end else begin
      word = in_data.src_pixel;
    end
    for (int c = 0; c < pfcb_pkg::NFIELD; c++) begin
      field_nxt[c] = (word >> pfcb_pkg::lay_off(cfg.src_layout, c))
                   & pfcb_pkg::field_mask(pfcb_pkg::lay_wid(cfg.src_layout, c));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r  <= in_data.last_pixel;
      s1_gray_r  <= in_data.src_pixel[pfcb_pkg::CH_W-1:0];
      s1_field_r <= field_nxt;
    end
  end

  // scale each field to an 8-bit channel
  always_comb begin
    dec_nxt       = '0;
    dec_nxt.valid = s1_valid_r;
    dec_nxt.last  = s1_last_r;
    w             = '0;
    unique case (cfg.src_mode)
      pfcb_pkg::SRC_GRAY8: begin
        for (int c = 0; c < pfcb_pkg::NCH; c++) dec_nxt.ch[c] = s1_gray_r;
      end
      pfcb_pkg::SRC_RGB16: begin
        for (int c = 0; c < pfcb_pkg::NCH; c++) begin
          w = pfcb_pkg::lay_wid(cfg.src_layout, c);
          dec_nxt.ch[c] = (w < pfcb_pkg::WIDE_FIELD) ? {s1_field_r[c][4:0], 3'b0}
                                                     : {s1_field_r[c][5:0], 2'b0};
        end
      end
      pfcb_pkg::SRC_GRAY_ALPHA16: begin
        for (int c = 0; c < pfcb_pkg::NCH; c++) begin
          dec_nxt.ch[c] = s1_field_r[0][pfcb_pkg::CH_W-1:0];
        end
        dec_nxt.alpha = s1_field_r[pfcb_pkg::ALPHA_IDX][pfcb_pkg::CH_W-1:0];
        dec_nxt.blend = 1'b1;
      end
      pfcb_pkg::SRC_RGB24: begin
        for (int c = 0; c < pfcb_pkg::NCH; c++) begin
          dec_nxt.ch[c] = s1_field_r[c][pfcb_pkg::CH_W-1:0];
        end
      end
      pfcb_pkg::SRC_RGBA32: begin
        for (int c = 0; c < pfcb_pkg::NCH; c++) begin
          dec_nxt.ch[c] = wide_down(s1_field_r[c], pfcb_pkg::lay_wid(cfg.src_layout, c));
        end
        w = pfcb_pkg::lay_wid(cfg.src_layout, pfcb_pkg::ALPHA_IDX);
        dec_nxt.alpha = wide_down(s1_field_r[pfcb_pkg::ALPHA_IDX], w);
        dec_nxt.blend = (w != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.valid <= 1'b0;
    end else if (adv) begin
      dec_r.valid <= dec_nxt.valid;
    end
    if (adv) begin
      dec_r.last  <= dec_nxt.last;
      dec_r.blend <= dec_nxt.blend;
      dec_r.alpha <= dec_nxt.alpha;
      dec_r.ch    <= dec_nxt.ch;
    end
  end

  assign dec_o = dec_r;

endmodule

// ===== rtl/pfcb_blend.sv =====
// Two-stage alpha blend over the background: products, then sum and wrap.
module pfcb_blend (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  pfcb_pkg::dec_t  dec_i,
  input  pfcb_pkg::cfg_t  cfg,
  output pfcb_pkg::mix_t  mix_o
);

  logic                                                s3_valid_r;
  logic                                                s3_last_r;
  logic                                                s3_blend_r;
  logic [pfcb_pkg::NCH-1:0][pfcb_pkg::CH_W-1:0]        s3_ch_r;
  logic [pfcb_pkg::NCH-1:0][pfcb_pkg::PROD_W-1:0]      s3_pca_r;
  logic [pfcb_pkg::NCH-1:0][pfcb_pkg::PROD_W-1:0]      s3_pib_r;
  logic [pfcb_pkg::NCH-1:0][pfcb_pkg::PROD_W-1:0]      pca_nxt;
  logic [pfcb_pkg::NCH-1:0][pfcb_pkg::PROD_W-1:0]      pib_nxt;
  logic [pfcb_pkg::NCH-1:0][pfcb_pkg::CH_W-1:0]        bg;
  logic [pfcb_pkg::CH_W-1:0]                           inv;
  pfcb_pkg::mix_t                                      mix_r;
  pfcb_pkg::mix_t                                      mix_nxt;
  logic [pfcb_pkg::PROD_W:0]                           straight;

  assign inv = pfcb_pkg::FULL_SCALE - dec_i.alpha;

  always_comb begin
    for (int c = 0; c < pfcb_pkg::NCH; c++) begin
      bg[c] = cfg.custom_bg
            ? cfg.bg_rgb[pfcb_pkg::CH_W*(pfcb_pkg::NCH-1-c) +: pfcb_pkg::CH_W]
            : pfcb_pkg::DEFAULT_BG;
      pca_nxt[c] = pfcb_pkg::PROD_W'(dec_i.ch[c]) * pfcb_pkg::PROD_W'(dec_i.alpha);
      pib_nxt[c] = pfcb_pkg::PROD_W'(inv) * pfcb_pkg::PROD_W'(bg[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= dec_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_last_r  <= dec_i.last;
      s3_blend_r <= dec_i.blend;
      s3_ch_r    <= dec_i.ch;
      s3_pca_r   <= pca_nxt;
      s3_pib_r   <= pib_nxt;
    end
  end

  // combine products; premultiplied colour wraps at 256
  always_comb begin
    mix_nxt       = '0;
    mix_nxt.valid = s3_valid_r;
    mix_nxt.last  = s3_last_r;
    straight      = '0;
    for (int c = 0; c < pfcb_pkg::NCH; c++) begin
      straight = {1'b0, s3_pca_r[c]} + {1'b0, s3_pib_r[c]};
      if (!s3_blend_r) begin
        mix_nxt.ch[c] = s3_ch_r[c];
      end else if (cfg.premult) begin
        mix_nxt.ch[c] = s3_ch_r[c] + s3_pib_r[c][pfcb_pkg::PROD_W-1 -: pfcb_pkg::CH_W];
      end else begin
        mix_nxt.ch[c] = straight[pfcb_pkg::PROD_W-1 -: pfcb_pkg::CH_W];
      end
    end
    mix_nxt.sum = pfcb_pkg::SUM_W'(mix_nxt.ch[0]) + pfcb_pkg::SUM_W'(mix_nxt.ch[1])
                + pfcb_pkg::SUM_W'(mix_nxt.ch[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r.valid <= 1'b0;
    end else if (adv) begin
      mix_r.valid <= mix_nxt.valid;
    end
    if (adv) begin
      mix_r.last <= mix_nxt.last;
      mix_r.ch   <= mix_nxt.ch;
      mix_r.sum  <= mix_nxt.sum;
    end
  end

  assign mix_o = mix_r;

endmodule

// ===== rtl/pfcb_pack.sv =====
// Destination packing stage and output register.
module pfcb_pack (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  pfcb_pkg::mix_t  mix_i,
  input  pfcb_pkg::cfg_t  cfg,
  output logic            out_valid,
  output pfcb_pkg::out_t  out_data
);

  logic [pfcb_pkg::SRC_LAY_W-1:0]        dlay;
  logic [2*pfcb_pkg::SUM_W-1:0]          div_prod;
  logic [pfcb_pkg::PIX_W-1:0]            gray_word;
  logic [pfcb_pkg::PIX_W-1:0]            rgb16_word;
  logic [pfcb_pkg::PIX_W-1:0]            packed_word;
  logic [pfcb_pkg::PIX_W-1:0]            wide_word;
  logic [pfcb_pkg::PIX_W-1:0]            ch_word;
  logic [pfcb_pkg::CH_W-1:0]             ch16;
  logic [pfcb_pkg::OFF_W-1:0]            off;
  logic [pfcb_pkg::WID_W-1:0]            w;
  logic [pfcb_pkg::WID_W-1:0]            up;
  logic [pfcb_pkg::WID_W:0]              sh;
  logic                                  out_valid_r;
  pfcb_pkg::out_t                        out_data_r;
  pfcb_pkg::out_t                        out_data_nxt;

  assign dlay = {{(pfcb_pkg::SRC_LAY_W-pfcb_pkg::DST_LAY_W){1'b0}}, cfg.dst_layout};

  // gray: divide the channel sum by three through a reciprocal
  assign div_prod  = pfcb_pkg::SUM_W'(mix_i.sum) * pfcb_pkg::DIV3_RECIP;
  assign gray_word = {{(pfcb_pkg::PIX_W-pfcb_pkg::CH_W){1'b0}},
                      div_prod[pfcb_pkg::DIV3_SHIFT +: pfcb_pkg::CH_W]};

  always_comb begin
    rgb16_word  = '0;
    packed_word = '0;
    wide_word   = '0;
    ch_word     = '0;
    ch16        = '0;
    off         = '0;
    w           = '0;
    up          = '0;
    sh          = '0;
    for (int c = 0; c < pfcb_pkg::NCH; c++) begin
      off     = pfcb_pkg::lay_off(dlay, c);
      w       = pfcb_pkg::lay_wid(dlay, c);
      ch_word = {{(pfcb_pkg::PIX_W-pfcb_pkg::CH_W){1'b0}}, mix_i.ch[c]};
      ch16    = (w < pfcb_pkg::WIDE_FIELD) ? (mix_i.ch[c] >> 3) : (mix_i.ch[c] >> 2);
      rgb16_word  = rgb16_word
                  | ({{(pfcb_pkg::PIX_W-pfcb_pkg::CH_W){1'b0}}, ch16} << off);
      packed_word = packed_word | (ch_word << off);
      // scale up then place: one shift by the combined amount, drop past bit 31
      up = (w > pfcb_pkg::CHAN_BITS) ? (w - pfcb_pkg::CHAN_BITS) : '0;
      sh = {2'b0, off} + {1'b0, up};
      if (sh < {1'b0, pfcb_pkg::FULL_WORD}) begin
        wide_word = wide_word | (ch_word << sh[pfcb_pkg::OFF_W-1:0]);
      end
    end
    rgb16_word = {16'b0, rgb16_word[15:0]};
  end

  always_comb begin
    out_data_nxt.last_out = mix_i.last;
    unique case (cfg.dst_mode)
      pfcb_pkg::DST_GRAY8:  out_data_nxt.dst_pixel = gray_word;
      pfcb_pkg::DST_RGB16:  out_data_nxt.dst_pixel = rgb16_word;
      pfcb_pkg::DST_PACKED: out_data_nxt.dst_pixel = packed_word;
      pfcb_pkg::DST_WIDE:   out_data_nxt.dst_pixel = wide_word;
      default:              out_data_nxt.dst_pixel = wide_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mix_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/pixel_format_convert_blend_top.sv =====
// Pixel format converter with alpha blend: five-stage pipeline top level.
//
// Use: configure the source and destination formats, the background colour
// and the blend mode over the APB-style port while the pipeline is empty,
// then stream source words in on in_valid/in_data. Each beat in gives exactly
// one beat out on out_valid/out_data, in order, with last_out copying the
// end-of-run mark.
// Stages: an accepted input beat passes the field extract, channel scale, blend
// products, blend sum and pack registers before out_valid rises.
// Throughput: one pixel per clock while no stall holds the output; every stage
// is a register a single item wide, all moving on one shared advance enable.
// Stall: while out_valid is high and out_stall is high, every stage holds,
// in_stall rises and the output beat stays unchanged; when the output beat is
// taken the pipeline moves in the same cycle, so a new beat is accepted
// while the next result is presented.
// Reset: rst_n (synchronous, active low) empties the pipeline and restores
// the register defaults: 24-bit source, packed 8-bit destination, straight
// alpha, gray 180 background.
module pixel_format_convert_blend_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pfcb_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pfcb_pkg::out_t                   out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pfcb_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [pfcb_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [pfcb_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  pfcb_pkg::cfg_t  cfg;
  pfcb_pkg::dec_t  dec;
  pfcb_pkg::mix_t  mix;
  logic            adv;

  // hold every stage while the output beat waits
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  pfcb_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  pfcb_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg),
    .dec_o    (dec)
  );

  pfcb_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .dec_i (dec),
    .cfg   (cfg),
    .mix_o (mix)
  );

  pfcb_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .mix_i     (mix),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the pixel format converter: streams pixels and checks each result beat.
module tb_top;

  // Source mode codes the block leaves unused
  localparam logic [2:0] SRC_UNUSED_LO = 3'd5;
  localparam logic [2:0] SRC_UNUSED_HI = 3'd7;

  // Channel layouts, alpha/blue/green/red from the top; each entry is {width, offset}
  localparam logic [pfcb_pkg::SRC_LAY_W-1:0] L565 =
    {6'd0, 5'd0, 6'd5, 5'd0, 6'd6, 5'd5, 6'd5, 5'd11};
  localparam logic [pfcb_pkg::SRC_LAY_W-1:0] L888 =
    {6'd0, 5'd0, 6'd8, 5'd0, 6'd8, 5'd8, 6'd8, 5'd16};
  localparam logic [pfcb_pkg::SRC_LAY_W-1:0] L8888 =
    {6'd8, 5'd24, 6'd8, 5'd0, 6'd8, 5'd8, 6'd8, 5'd16};
  localparam logic [pfcb_pkg::SRC_LAY_W-1:0] L1010102 =
    {6'd2, 5'd30, 6'd10, 5'd0, 6'd10, 5'd10, 6'd10, 5'd20};
  localparam logic [pfcb_pkg::SRC_LAY_W-1:0] LGA =
    {6'd8, 5'd8, 11'd0, 11'd0, 6'd8, 5'd0};
  localparam logic [pfcb_pkg::DST_LAY_W-1:0] D565 =
    {6'd5, 5'd0, 6'd6, 5'd5, 6'd5, 5'd11};
  localparam logic [pfcb_pkg::DST_LAY_W-1:0] D888 =
    {6'd8, 5'd0, 6'd8, 5'd8, 6'd8, 5'd16};
  localparam logic [pfcb_pkg::DST_LAY_W-1:0] D101010 =
    {6'd10, 5'd0, 6'd10, 5'd10, 6'd10, 5'd20};

  localparam int RANDOM_PHASES    = 16;
  localparam int PIXELS_PER_PHASE = 106;
  localparam int SETTLE_CYCLES    = 20;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  pfcb_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_stall;
  pfcb_pkg::out_t                  out_data;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [pfcb_pkg::APB_ADDR_W-1:0] cfg_paddr;
  logic [pfcb_pkg::APB_DATA_W-1:0] cfg_pwdata;
  logic [pfcb_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  pfcb_pkg::cfg_t shadow_cfg;
  pfcb_pkg::out_t pixel_expect_q[$];
  int             send_idle_pct;
  int             stall_pct;
  int             error_count;
  int             pixels_sent;
  int             beats_checked;
  int             settings_applied;
  int             reg_writes;

  pixel_format_convert_blend_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("%s", what);
  endtask

  function automatic logic [pfcb_pkg::OFF_W-1:0] offset_of(
    input logic [pfcb_pkg::SRC_LAY_W-1:0] lay, input int c);
    return lay[pfcb_pkg::LAY_STRIDE*c +: pfcb_pkg::OFF_W];
  endfunction

  function automatic logic [pfcb_pkg::WID_W-1:0] width_of(
    input logic [pfcb_pkg::SRC_LAY_W-1:0] lay, input int c);
    return lay[pfcb_pkg::LAY_STRIDE*c + pfcb_pkg::OFF_W +: pfcb_pkg::WID_W];
  endfunction

  // A width of 32 or more takes every bit above the offset
  function automatic logic [63:0] pick_field(input logic [pfcb_pkg::PIX_W-1:0] word,
                                             input logic [pfcb_pkg::SRC_LAY_W-1:0] lay,
                                             input int c);
    logic [pfcb_pkg::WID_W-1:0] wid;
    logic [63:0]                mask;
    wid = width_of(lay, c);
    if (wid >= 6'd32) mask = 64'hFFFF_FFFF;
    else mask = (64'd1 << wid) - 64'd1;
    return ({32'd0, word} >> offset_of(lay, c)) & mask;
  endfunction

  function automatic pfcb_pkg::out_t convert_pixel(input pfcb_pkg::cfg_t cfg,
                                                   input pfcb_pkg::in_t px);
    logic [pfcb_pkg::NCH-1:0][pfcb_pkg::CH_W-1:0] chan;
    logic [pfcb_pkg::CH_W-1:0]                    alpha;
    logic                                         blend;
    logic [pfcb_pkg::PIX_W-1:0]                   word;
    logic [pfcb_pkg::SRC_LAY_W-1:0]               dlay;
    logic [63:0]                                  fld;
    logic [63:0]                                  v;
    logic [63:0]                                  res;
    logic [pfcb_pkg::WID_W-1:0]                   w;
    int unsigned                                  inv;
    int unsigned                                  bgc;
    int unsigned                                  sum;
    pfcb_pkg::out_t                               r;
    chan  = '0;
    alpha = '0;
    blend = 1'b0;
    res   = '0;
    dlay  = pfcb_pkg::SRC_LAY_W'(cfg.dst_layout);
    case (cfg.src_mode)
      pfcb_pkg::SRC_GRAY8: begin
        for (int c = 0; c < pfcb_pkg::NCH; c++) chan[c] = px.src_pixel[7:0];
      end
      pfcb_pkg::SRC_RGB16: begin
        word = {16'd0, px.src_pixel[15:0]};
        for (int c = 0; c < pfcb_pkg::NCH; c++) begin
          fld = pick_field(word, cfg.src_layout, c);
          w = width_of(cfg.src_layout, c);
          fld = fld << ((w < pfcb_pkg::WIDE_FIELD) ? 3 : 2);
          chan[c] = fld[7:0];
        end
      end
      pfcb_pkg::SRC_GRAY_ALPHA16: begin
        word = {16'd0, px.src_pixel[15:0]};
        fld = pick_field(word, cfg.src_layout, 0);
        for (int c = 0; c < pfcb_pkg::NCH; c++) chan[c] = fld[7:0];
        fld = pick_field(word, cfg.src_layout, pfcb_pkg::ALPHA_IDX);
        alpha = fld[7:0];
        blend = 1'b1;
      end
      pfcb_pkg::SRC_RGB24: begin
        word = {8'd0, px.src_pixel[23:0]};
        for (int c = 0; c < pfcb_pkg::NCH; c++) begin
          fld = pick_field(word, cfg.src_layout, c);
          chan[c] = fld[7:0];
        end
      end
      pfcb_pkg::SRC_RGBA32: begin
        for (int c = 0; c < pfcb_pkg::NFIELD; c++) begin
          fld = pick_field(px.src_pixel, cfg.src_layout, c);
          w = width_of(cfg.src_layout, c);
          if (w > pfcb_pkg::CHAN_BITS) fld = fld >> (w - pfcb_pkg::CHAN_BITS);
          if (c == pfcb_pkg::ALPHA_IDX) alpha = fld[7:0];
          else chan[c] = fld[7:0];
        end
        blend = (width_of(cfg.src_layout, pfcb_pkg::ALPHA_IDX) != 6'd0);
      end
      default: ;
    endcase

    if (blend) begin
      for (int c = 0; c < pfcb_pkg::NCH; c++) begin
        bgc = cfg.custom_bg ? 32'(cfg.bg_rgb[16-8*c +: 8]) : 32'(pfcb_pkg::DEFAULT_BG);
        inv = 32'(pfcb_pkg::FULL_SCALE) - 32'(alpha);
        // premultiplied sum wraps at a byte
        if (cfg.premult) sum = 32'(chan[c]) + ((inv * bgc) >> 8);
        else sum = (32'(chan[c]) * 32'(alpha) + inv * bgc) >> 8;
        chan[c] = 8'(sum);
      end
    end

    case (cfg.dst_mode)
      pfcb_pkg::DST_GRAY8: begin
        sum = 32'(chan[0]) + 32'(chan[1]) + 32'(chan[2]);
        res = 64'(sum / 3);
      end
      pfcb_pkg::DST_RGB16: begin
        for (int c = 0; c < pfcb_pkg::NCH; c++) begin
          w = width_of(dlay, c);
          v = 64'(chan[c]) >> ((w < pfcb_pkg::WIDE_FIELD) ? 3 : 2);
          res |= v << offset_of(dlay, c);
        end
        res &= 64'hFFFF;
      end
      pfcb_pkg::DST_PACKED: begin
        for (int c = 0; c < pfcb_pkg::NCH; c++) res |= 64'(chan[c]) << offset_of(dlay, c);
      end
      default: begin
        for (int c = 0; c < pfcb_pkg::NCH; c++) begin
          w = width_of(dlay, c);
          v = 64'(chan[c]);
          if (w > pfcb_pkg::CHAN_BITS) v = v << (w - pfcb_pkg::CHAN_BITS);
          v &= 64'hFFFF_FFFF;
          res |= v << offset_of(dlay, c);
        end
      end
    endcase
    r.dst_pixel = res[31:0];
    r.last_out  = px.last_pixel;
    return r;
  endfunction

  function automatic logic [63:0] reg_value(input logic [pfcb_pkg::REG_IDX_W-1:0] idx);
    case (idx)
      pfcb_pkg::REG_SRC_MODE:   return 64'(shadow_cfg.src_mode);
      pfcb_pkg::REG_SRC_LAYOUT: return 64'(shadow_cfg.src_layout);
      pfcb_pkg::REG_DST_MODE:   return 64'(shadow_cfg.dst_mode);
      pfcb_pkg::REG_DST_LAYOUT: return 64'(shadow_cfg.dst_layout);
      pfcb_pkg::REG_CUSTOM_BG:  return 64'(shadow_cfg.custom_bg);
      pfcb_pkg::REG_PREMULT:    return 64'(shadow_cfg.premult);
      pfcb_pkg::REG_BG_RGB:     return 64'(shadow_cfg.bg_rgb);
      default:                  return '0;
    endcase
  endfunction

  // Setup cycle, access cycle, then the bus goes idle
  task automatic apb_access(input logic wr, input logic [pfcb_pkg::REG_IDX_W-1:0] idx,
                            input logic [63:0] wdata, output logic [63:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= pfcb_pkg::APB_ADDR_W'({idx, 3'b000});
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input logic [pfcb_pkg::REG_IDX_W-1:0] idx);
    logic [63:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx))
      flag_error($sformatf("register %0d read back 0x%0h, expected 0x%0h",
                           idx, rd, reg_value(idx)));
  endtask

  task automatic cfg_write(input logic [pfcb_pkg::REG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    logic [63:0] rd;
    apb_access(1'b1, idx, val, rd);
    case (idx)
      pfcb_pkg::REG_SRC_MODE:   shadow_cfg.src_mode   = val[2:0];
      pfcb_pkg::REG_SRC_LAYOUT: shadow_cfg.src_layout = val[pfcb_pkg::SRC_LAY_W-1:0];
      pfcb_pkg::REG_DST_MODE:   shadow_cfg.dst_mode   = val[1:0];
      pfcb_pkg::REG_DST_LAYOUT: shadow_cfg.dst_layout = val[pfcb_pkg::DST_LAY_W-1:0];
      pfcb_pkg::REG_CUSTOM_BG:  shadow_cfg.custom_bg  = val[0];
      pfcb_pkg::REG_PREMULT:    shadow_cfg.premult    = val[0];
      pfcb_pkg::REG_BG_RGB:     shadow_cfg.bg_rgb     = val[pfcb_pkg::BG_W-1:0];
      default: ;
    endcase
    reg_writes++;
    check_reg(idx);
  endtask

  // Drop valid and wait for every outstanding beat
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic apply_setting(input pfcb_pkg::cfg_t s);
    drain_pixels();
    cfg_write(pfcb_pkg::REG_SRC_MODE, 64'(s.src_mode));
    cfg_write(pfcb_pkg::REG_SRC_LAYOUT, 64'(s.src_layout));
    cfg_write(pfcb_pkg::REG_DST_MODE, 64'(s.dst_mode));
    cfg_write(pfcb_pkg::REG_DST_LAYOUT, 64'(s.dst_layout));
    cfg_write(pfcb_pkg::REG_CUSTOM_BG, 64'(s.custom_bg));
    cfg_write(pfcb_pkg::REG_PREMULT, 64'(s.premult));
    cfg_write(pfcb_pkg::REG_BG_RGB, 64'(s.bg_rgb));
    settings_applied++;
  endtask

  task automatic set_idling(input idle_mode_t m);
    send_idle_pct = (m == IDLE_SENDER) ? 80 : (m == IDLE_BOTH) ? 9 : 0;
    stall_pct     = (m == IDLE_RECEIVER) ? 80 : (m == IDLE_BOTH) ? 9 : 0;
  endtask

  // Entered and left at a falling edge; valid stays up for a following beat
  task automatic send_pixel(input pfcb_pkg::in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixel_expect_q.push_back(convert_pixel(shadow_cfg, px));
    pixels_sent++;
    @(negedge clk);
  endtask

  function automatic pfcb_pkg::in_t make_pixel(input logic [pfcb_pkg::PIX_W-1:0] word,
                                               input logic last);
    pfcb_pkg::in_t px;
    px.src_pixel  = word;
    px.last_pixel = last;
    return px;
  endfunction

  function automatic pfcb_pkg::in_t random_pixel();
    pfcb_pkg::in_t px;
    case ($urandom_range(15))
      0:       px.src_pixel = '0;
      1:       px.src_pixel = '1;
      default: px.src_pixel = $urandom;
    endcase
    px.last_pixel = ($urandom_range(7) == 0);
    return px;
  endfunction

  function automatic logic [pfcb_pkg::WID_W-1:0] random_width();
    case ($urandom_range(9))
      0:       return 6'd0;
      1:       return 6'($urandom_range(1, 4));
      2:       return 6'd5;
      3:       return 6'd6;
      4:       return 6'd7;
      5, 6:    return 6'd8;
      7:       return 6'($urandom_range(9, 16));
      8:       return 6'($urandom_range(17, 31));
      default: return 6'($urandom_range(32, 63));
    endcase
  endfunction

  function automatic logic [pfcb_pkg::SRC_LAY_W-1:0] random_fields(input int n);
    logic [pfcb_pkg::SRC_LAY_W-1:0] lay;
    lay = '0;
    for (int i = 0; i < n; i++)
      lay[pfcb_pkg::LAY_STRIDE*i +: pfcb_pkg::LAY_STRIDE] =
        {random_width(), 5'($urandom_range(31))};
    return lay;
  endfunction

  // Phase 0 takes every register to its bottom, phase 1 all but src_mode to its top;
  // the rest mostly use layouts that suit the mode, with some odd and fully random ones
  function automatic pfcb_pkg::cfg_t random_setting(input int phase);
    pfcb_pkg::cfg_t s;
    int             pick;
    if (phase == 0) begin
      s = '0;
      return s;
    end
    if (phase == 1) begin
      s.src_mode   = pfcb_pkg::SRC_RGBA32;
      s.src_layout = '1;
      s.dst_mode   = pfcb_pkg::DST_WIDE;
      s.dst_layout = '1;
      s.custom_bg  = 1'b1;
      s.premult    = 1'b1;
      s.bg_rgb     = '1;
      return s;
    end
    s.src_mode = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    pick = $urandom_range(9);
    if (pick < 6) begin
      case (s.src_mode)
        pfcb_pkg::SRC_RGB16:        s.src_layout = L565;
        pfcb_pkg::SRC_GRAY_ALPHA16: s.src_layout = LGA;
        pfcb_pkg::SRC_RGBA32:       s.src_layout = $urandom_range(1) ? L8888 : L1010102;
        default:                    s.src_layout = L888;
      endcase
    end else if (pick < 9) begin
      s.src_layout = random_fields(pfcb_pkg::NFIELD);
    end else begin
      s.src_layout = pfcb_pkg::SRC_LAY_W'({$urandom, $urandom});
    end
    s.dst_mode = 2'($urandom_range(3));
    pick = $urandom_range(9);
    if (pick < 6) begin
      case (s.dst_mode)
        pfcb_pkg::DST_RGB16: s.dst_layout = D565;
        pfcb_pkg::DST_WIDE:  s.dst_layout = D101010;
        default:             s.dst_layout = D888;
      endcase
    end else if (pick < 9) begin
      s.dst_layout = pfcb_pkg::DST_LAY_W'(random_fields(pfcb_pkg::NCH));
    end else begin
      s.dst_layout = pfcb_pkg::DST_LAY_W'({$urandom, $urandom});
    end
    s.custom_bg = 1'($urandom_range(1));
    s.premult   = 1'($urandom_range(1));
    s.bg_rgb    = 24'($urandom);
    return s;
  endfunction

  task automatic test_reset_values();
    for (int i = pfcb_pkg::REG_SRC_MODE; i <= pfcb_pkg::REG_BG_RGB; i++)
      check_reg(pfcb_pkg::REG_IDX_W'(i));
    send_pixel(make_pixel(32'hFFFF_FFFF, 1'b0));
    send_pixel(make_pixel(32'h0000_0000, 1'b1));
    send_pixel(make_pixel(32'hA5C3_0F81, 1'b0));
  endtask

  task automatic test_directed_formats();
    pfcb_pkg::cfg_t s;
    set_idling(IDLE_NONE);
    s.src_mode   = pfcb_pkg::SRC_GRAY8;
    s.src_layout = '0;
    s.dst_mode   = pfcb_pkg::DST_PACKED;
    s.dst_layout = D888;
    s.custom_bg  = 1'b0;
    s.premult    = 1'b0;
    s.bg_rgb     = {3{pfcb_pkg::DEFAULT_BG}};
    apply_setting(s);
    send_pixel(make_pixel(32'h0000_0000, 1'b0));
    send_pixel(make_pixel(32'hFFFF_FF00, 1'b0));
    send_pixel(make_pixel(32'h0000_00FF, 1'b1));

    // five- and six-bit fields scale by different shifts
    s.src_mode   = pfcb_pkg::SRC_RGB16;
    s.src_layout = L565;
    s.dst_mode   = pfcb_pkg::DST_RGB16;
    s.dst_layout = D565;
    apply_setting(s);
    send_pixel(make_pixel(32'hFFFF_FFFF, 1'b0));
    send_pixel(make_pixel(32'hFFFF_0000, 1'b0));
    send_pixel(make_pixel(32'h0000_F81F, 1'b1));

    // alpha zero, full and half over the fixed grey, averaged to gray
    s.src_mode   = pfcb_pkg::SRC_GRAY_ALPHA16;
    s.src_layout = LGA;
    s.dst_mode   = pfcb_pkg::DST_GRAY8;
    apply_setting(s);
    send_pixel(make_pixel(32'h0000_00FF, 1'b0));
    send_pixel(make_pixel(32'h0000_FF80, 1'b0));
    send_pixel(make_pixel(32'hFFFF_80FF, 1'b1));

    // premultiplied over white: the channel sum wraps
    s.premult    = 1'b1;
    s.custom_bg  = 1'b1;
    s.bg_rgb     = 24'hFFFFFF;
    s.dst_mode   = pfcb_pkg::DST_PACKED;
    s.dst_layout = D888;
    apply_setting(s);
    send_pixel(make_pixel(32'h0000_00FF, 1'b0));
    send_pixel(make_pixel(32'h0000_40C0, 1'b1));

    // 32-bit source without an alpha field: no blend
    s.src_mode   = pfcb_pkg::SRC_RGBA32;
    s.src_layout = L888;
    s.dst_mode   = pfcb_pkg::DST_WIDE;
    s.dst_layout = D101010;
    s.premult    = 1'b0;
    apply_setting(s);
    send_pixel(make_pixel(32'hFFFF_FFFF, 1'b0));
    send_pixel(make_pixel(32'h1234_5678, 1'b1));

    // wide source fields, a full-word field, placement at the top bit
    s.src_layout = {6'd40, 5'd4, 6'd1, 5'd31, 6'd16, 5'd8, 6'd32, 5'd0};
    s.dst_mode   = pfcb_pkg::DST_PACKED;
    s.dst_layout = {6'd8, 5'd0, 6'd8, 5'd24, 6'd8, 5'd31};
    s.custom_bg  = 1'b0;
    apply_setting(s);
    send_pixel(make_pixel(32'hFFFF_FFFF, 1'b0));
    send_pixel(make_pixel(32'h8000_0000, 1'b0));
    send_pixel(make_pixel(32'h7FFF_FFFE, 1'b1));

    // unused source codes give black
    s.src_mode = SRC_UNUSED_LO;
    apply_setting(s);
    send_pixel(make_pixel(32'hFFFF_FFFF, 1'b0));
    s.src_mode = SRC_UNUSED_HI;
    apply_setting(s);
    send_pixel(make_pixel(32'hFFFF_FFFF, 1'b1));

    // oversize 24-bit field kept to a byte; wide channels shifted past bit 31
    s.src_mode   = pfcb_pkg::SRC_RGB24;
    s.src_layout = {11'd0, 6'd8, 5'd0, 6'd8, 5'd8, 6'd12, 5'd12};
    s.dst_mode   = pfcb_pkg::DST_WIDE;
    s.dst_layout = {6'd63, 5'd0, 6'd12, 5'd4, 6'd9, 5'd31};
    apply_setting(s);
    send_pixel(make_pixel(32'hFFFF_FFFF, 1'b0));
    send_pixel(make_pixel(32'h00AB_CDEF, 1'b1));
  endtask

  task automatic test_random_streams();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_setting(random_setting(phase));
      set_idling(idle_mode_t'(phase % 4));
      repeat (PIXELS_PER_PHASE) send_pixel(random_pixel());
    end
  endtask

  always @(posedge clk) begin : check_results
    pfcb_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_expect_q.size() == 0) begin
        flag_error($sformatf("result beat 0x%08h with none outstanding",
                             out_data.dst_pixel));
      end else begin
        want = pixel_expect_q.pop_front();
        if (out_data.dst_pixel !== want.dst_pixel || out_data.last_out !== want.last_out)
          flag_error($sformatf("beat %0d: expected dst 0x%08h last %0b, got dst 0x%08h last %0b",
                               beats_checked, want.dst_pixel, want.last_out,
                               out_data.dst_pixel, out_data.last_out));
      end
      beats_checked++;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    shadow_cfg.src_mode   = pfcb_pkg::SRC_RGB24;
    shadow_cfg.src_layout = '0;
    shadow_cfg.dst_mode   = pfcb_pkg::DST_PACKED;
    shadow_cfg.dst_layout = '0;
    shadow_cfg.custom_bg  = 1'b0;
    shadow_cfg.premult    = 1'b0;
    shadow_cfg.bg_rgb     = {3{pfcb_pkg::DEFAULT_BG}};
    error_count      = 0;
    pixels_sent      = 0;
    beats_checked    = 0;
    settings_applied = 0;
    reg_writes       = 0;
    set_idling(IDLE_NONE);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_directed_formats();
    test_random_streams();

    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pixel_expect_q.size() != 0)
      flag_error($sformatf("%0d result beats never arrived", pixel_expect_q.size()));

    $display("%0d pixels sent under %0d register settings (%0d writes, each read back)",
             pixels_sent, settings_applied, reg_writes);
    $display("%0d result beats checked, %0d failures", beats_checked, error_count);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("run timed out");
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfcb_pkg.sv
rtl/pfcb_cfg.sv
rtl/pfcb_decode.sv
rtl/pfcb_blend.sv
rtl/pfcb_pack.sv
rtl/pixel_format_convert_blend_top.sv
sim/tb_top.sv
